// File: src/hpt_pkg.sv
// ----------------------------------------------------------------------------
// hpt_pkg
// Shared constants for the histogram peak threshold block: bin geometry,
// configuration register indexes and their reset values.
// ----------------------------------------------------------------------------
package hpt_pkg;

    localparam int NUM_BINS       = 256;
    localparam int BIN_BITS       = 8;
    localparam int COUNT_BITS_DEF = 21;

    localparam int PIXEL_BITS     = 8;
    localparam int PCT_BITS       = 7;
    localparam int PCT_SCALE      = 100;
    localparam int PCT_SCALE_BITS = 7;

    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 8;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_PERCENT   = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MIN_LEVEL = 2'd1;

    localparam logic [PCT_BITS-1:0]   PERCENT_RESET   = 7'd5;
    localparam logic [PIXEL_BITS-1:0] MIN_LEVEL_RESET = 8'd0;

    localparam logic [BIN_BITS-1:0] BIN_LAST = BIN_BITS'(NUM_BINS - 1);

endpackage

// File: src/histogram_peak_threshold_top.sv
// ----------------------------------------------------------------------------
// histogram_peak_threshold_top
// Per-frame grey-level histogram with a peak-fraction valley threshold.
//
// Usage:
//   s_* stream carries one pixel per transfer, s_tlast on the frame's final
//   pixel. Pixels below or at min_level land in bin 0. After the last pixel
//   the block scans the histogram and sends one m_* transfer holding the
//   threshold level and the peak bin. cfg_* writes percent (index 0) and
//   min_level (index 1); always ready; users must use it only while idle, unchecked.
// Throughput and sequence:
//   During a frame one pixel is taken per cycle; the bin counts sit in a
//   single 256-entry memory updated by a two-stage read-modify-write with
//   forwarding between back-to-back pixels on the same bin.
//   After the last pixel: a drain state, the peak scan, the cutoff product,
//   the valley scan, the load of the result, then the clearing of the memory.
//   m_tvalid rises once the result is loaded. s_tready is low over all of
//   this and rises again when the clearing is done, later when the previous
//   result is still waiting in the result register.
// Reset and stall:
//   After aresetn the memory is cleared before s_tready rises.
//   The result register holds while m_tready is low; the next frame is taken
//   meanwhile, and its result waits until the previous one is transferred.
// ----------------------------------------------------------------------------
module histogram_peak_threshold_top #(
    parameter int COUNT_BITS = hpt_pkg::COUNT_BITS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // pixel stream
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [7:0]                         s_tdata,   // [7:0] pixel
    input  logic                               s_tlast,   // last pixel of frame
    // result stream
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [15:0]                        m_tdata,   // [7:0] threshold_level,
                                                          // [15:8] peak_bin
    // configuration writes
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [hpt_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [hpt_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
    import hpt_pkg::*;

    localparam int PROD_BITS = COUNT_BITS + PCT_BITS;
    localparam int CMP_BITS  = COUNT_BITS + 1 + PCT_SCALE_BITS;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_COLLECT,
        ST_DRAIN,
        ST_PEAK,
        ST_MULT,
        ST_VALLEY,
        ST_FINISH
    } state_t;

    state_t state_reg, state_next;

    logic [COUNT_BITS-1:0] mem [NUM_BINS];
    logic [COUNT_BITS-1:0] rd_data_reg;
    logic [BIN_BITS-1:0]   rd_addr;
    logic                  wr_en;
    logic [BIN_BITS-1:0]   wr_addr;
    logic [COUNT_BITS-1:0] wr_data;

    logic [BIN_BITS:0]     idx_reg;
    logic                  rd_valid_reg;
    logic [BIN_BITS-1:0]   rd_bin_reg;

    logic                  st1_valid_reg;
    logic [BIN_BITS-1:0]   st1_bin_reg;
    logic                  fwd_valid_reg;
    logic [BIN_BITS-1:0]   fwd_bin_reg;
    logic [COUNT_BITS-1:0] fwd_count_reg;

    logic [COUNT_BITS-1:0] best_count_reg;
    logic [BIN_BITS-1:0]   best_bin_reg;
    logic [PROD_BITS-1:0]  prod_reg;
    logic [BIN_BITS-1:0]   thr_reg;

    logic [PCT_BITS-1:0]   percent_reg;
    logic [PIXEL_BITS-1:0] min_level_reg;

    logic                  m_valid_reg;
    logic [15:0]           m_data_reg;

    logic                  s_accept;
    logic [BIN_BITS-1:0]   pix_bin;
    logic [COUNT_BITS-1:0] cur_count;
    logic [COUNT_BITS-1:0] inc_count;
    logic [COUNT_BITS:0]   valley_inc;
    logic [CMP_BITS-1:0]   valley_scaled;
    logic                  valley_hit;
    logic                  out_free;

    assign s_tready  = (state_reg == ST_COLLECT);
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;
    assign out_free  = !m_valid_reg || m_tready;

    assign pix_bin = (s_tdata <= min_level_reg) ? '0 : s_tdata;

    // Forward the count written last cycle: the memory returns old data on
    // a read that lands on the same edge as the write.
    assign cur_count = (fwd_valid_reg && (fwd_bin_reg == st1_bin_reg)) ?
                       fwd_count_reg : rd_data_reg;
    assign inc_count = (&cur_count) ? cur_count : cur_count + COUNT_BITS'(1);

    // count < floor(peak * pct / 100)  <=>  100 * (count + 1) <= peak * pct
    assign valley_inc    = {1'b0, rd_data_reg} + (COUNT_BITS + 1)'(1);
    assign valley_scaled = CMP_BITS'(valley_inc) * CMP_BITS'(PCT_SCALE);
    assign valley_hit    = valley_scaled <= CMP_BITS'(prod_reg);

    always_comb begin
        rd_addr = (state_reg == ST_COLLECT) ? pix_bin : idx_reg[BIN_BITS-1:0];
        wr_en   = st1_valid_reg || (state_reg == ST_CLEAR);
        wr_addr = st1_valid_reg ? st1_bin_reg : idx_reg[BIN_BITS-1:0];
        wr_data = st1_valid_reg ? inc_count : '0;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:   if (idx_reg[BIN_BITS-1:0] == BIN_LAST) state_next = ST_COLLECT;
            ST_COLLECT: if (s_accept && s_tlast) state_next = ST_DRAIN;
            ST_DRAIN:   state_next = ST_PEAK;
            ST_PEAK:    if (rd_valid_reg && rd_bin_reg == BIN_LAST) state_next = ST_MULT;
            ST_MULT:    state_next = ST_VALLEY;
            ST_VALLEY: begin
                if ((rd_valid_reg && valley_hit) || (idx_reg[BIN_BITS] && !rd_valid_reg)) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:  if (out_free) state_next = ST_CLEAR;
            default:    state_next = ST_CLEAR;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_CLEAR;
            idx_reg        <= '0;
            rd_valid_reg   <= 1'b0;
            st1_valid_reg  <= 1'b0;
            fwd_valid_reg  <= 1'b0;
            best_count_reg <= '0;
            best_bin_reg   <= '0;
            m_valid_reg    <= 1'b0;
            percent_reg    <= PERCENT_RESET;
            min_level_reg  <= MIN_LEVEL_RESET;
        end else begin
            state_reg <= state_next;

            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_PERCENT:   percent_reg   <= cfg_data[PCT_BITS-1:0];
                    CFG_MIN_LEVEL: min_level_reg <= cfg_data[PIXEL_BITS-1:0];
                    default:       ;
                endcase
            end

            // histogram update pipeline
            st1_valid_reg <= s_accept;
            st1_bin_reg   <= pix_bin;
            fwd_valid_reg <= st1_valid_reg;
            fwd_bin_reg   <= st1_bin_reg;
            fwd_count_reg <= inc_count;

            case (state_reg)
                ST_CLEAR: begin
                    rd_valid_reg <= 1'b0;
                    idx_reg <= (idx_reg[BIN_BITS-1:0] == BIN_LAST) ? '0 : idx_reg + 1'b1;
                end
                ST_COLLECT: begin
                    rd_valid_reg   <= 1'b0;
                    idx_reg        <= '0;
                    best_count_reg <= '0;
                    best_bin_reg   <= '0;
                end
                ST_DRAIN: begin
                    rd_valid_reg <= 1'b0;
                end
                ST_PEAK: begin
                    rd_valid_reg <= !idx_reg[BIN_BITS];
                    if (!idx_reg[BIN_BITS]) begin
                        rd_bin_reg <= idx_reg[BIN_BITS-1:0];
                        idx_reg    <= idx_reg + 1'b1;
                    end
                    if (rd_valid_reg && rd_data_reg > best_count_reg) begin
                        best_count_reg <= rd_data_reg;
                        best_bin_reg   <= rd_bin_reg;
                    end
                end
                ST_MULT: begin
                    rd_valid_reg <= 1'b0;
                    prod_reg <= PROD_BITS'(best_count_reg) * PROD_BITS'(percent_reg);
                    idx_reg  <= {1'b0, best_bin_reg} + (BIN_BITS + 1)'(1);
                    thr_reg  <= best_bin_reg;
                end
                ST_VALLEY: begin
                    if (rd_valid_reg && valley_hit) begin
                        rd_valid_reg <= 1'b0;
                        thr_reg      <= rd_bin_reg;
                    end else if (!idx_reg[BIN_BITS]) begin
                        rd_valid_reg <= 1'b1;
                        rd_bin_reg   <= idx_reg[BIN_BITS-1:0];
                        idx_reg      <= idx_reg + 1'b1;
                    end else begin
                        rd_valid_reg <= 1'b0;
                    end
                end
                ST_FINISH: begin
                    rd_valid_reg <= 1'b0;
                    idx_reg      <= '0;
                    if (out_free) begin
                        m_data_reg <= {best_bin_reg, thr_reg};
                    end
                end
                default: begin
                    rd_valid_reg <= 1'b0;
                end
            endcase

            if (state_reg == ST_FINISH && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // A pixel update only follows a pixel transfer in the collect state.
    assert property (@(posedge aclk) disable iff (!aresetn)
        st1_valid_reg |-> $past(state_reg == ST_COLLECT))
        else $error("bin update outside collect state");

    // The clearing sweep never shares the write port with a pixel update.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(st1_valid_reg && state_reg == ST_CLEAR))
        else $error("write port conflict between clear and update");

    // A result appears only out of the finish state.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_FINISH))
        else $error("result raised outside finish state");

    // The threshold never lies below the peak bin.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_data_reg[7:0] >= m_data_reg[15:8]))
        else $error("threshold below peak bin");

    // No pixel is taken while the scan or the clearing sweep runs.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_PEAK || state_reg == ST_VALLEY || state_reg == ST_CLEAR)
        |-> !s_tready)
        else $error("input ready during scan or clear");

endmodule
